// File: rtl/core/bdl_pkg.sv
// Shared types and codes for the bounded double-ended list.
// Holds the command and result item structs, command codes and status codes.
// No dependencies.
package bdl_pkg;

    localparam int unsigned CMD_W      = 3;
    localparam int unsigned ELEM_IO_W  = 32;
    localparam int unsigned POS_W      = 8;
    localparam int unsigned COUNT_IO_W = 9;
    localparam int unsigned STATUS_W   = 2;

    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REM_HEAD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_TAIL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RD_HEAD  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RD_TAIL  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RD_INDEX = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [ELEM_IO_W-1:0] element_in;
        logic [POS_W-1:0]     position;
    } t_cmd_item;

    typedef struct packed {
        logic [ELEM_IO_W-1:0]  element_out;
        logic [COUNT_IO_W-1:0] entry_count;
        logic [STATUS_W-1:0]   status;
    } t_result;

endpackage

// File: rtl/core/bounded_double_ended_list.sv
// Bounded double-ended list over a ring buffer in one synchronous memory.
// Pipeline: memory read into stage 1, then the output register, which drives o_valid;
// throughput 1 item per cycle while i_ready does not stall it, set by the single memory
// port (one read or one write per command).
// Reset: head pointer, count and all valid flags clear; the element memory
// keeps its contents and needs no clearing pass.
// Depends on bdl_pkg.
module bounded_double_ended_list #(
    parameter int unsigned CAPACITY      = 256,
    parameter int unsigned ELEMENT_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  bdl_pkg::t_cmd_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output bdl_pkg::t_result     o_item
);
    import bdl_pkg::*;

    localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [ELEMENT_WIDTH-1:0] r_mem [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] r_rdata;

    logic [PW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;

    logic                  r_s1_valid;
    logic                  r_s1_rd;
    logic [COUNT_IO_W-1:0] r_s1_count;
    logic [STATUS_W-1:0]   r_s1_status;

    logic                  r_out_valid;
    t_result               r_out;

    logic                  accept;
    logic                  s1_adv;
    logic                  full;
    logic                  empty;
    logic                  mem_we;
    logic                  mem_re;
    logic                  rd_ok;
    logic [STATUS_W-1:0]   status;
    logic [PW-1:0]         offset;
    logic [PW-1:0]         head_dec;
    logic [PW:0]           slot_sum;
    logic [PW-1:0]         slot;
    logic [PW-1:0]         addr;

    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_adv;
    assign accept  = i_valid && o_ready;

    assign full     = (r_count == CW'(CAPACITY));
    assign empty    = (r_count == '0);
    assign head_dec = (r_head == '0) ? PW'(CAPACITY - 1) : PW'(r_head - 1'b1);
    assign slot_sum = {1'b0, r_head} + {1'b0, offset};
    assign slot     = (slot_sum >= (PW+1)'(CAPACITY)) ? PW'(slot_sum - (PW+1)'(CAPACITY))
                                                      : slot_sum[PW-1:0];
    assign addr     = (i_item.command == CMD_INS_HEAD) ? head_dec : slot;

    always_comb begin
        n_head = r_head;
        n_count = r_count;
        mem_we = 1'b0;
        mem_re = 1'b0;
        rd_ok = 1'b0;
        status = ST_OK;
        offset = '0;
        unique case (i_item.command)
            CMD_INS_HEAD: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    mem_we = 1'b1;
                    n_head = head_dec;
                    n_count = CW'(r_count + 1'b1);
                end
            end
            CMD_INS_TAIL: begin
                offset = PW'(r_count);
                if (full) begin
                    status = ST_FULL;
                end else begin
                    mem_we = 1'b1;
                    n_count = CW'(r_count + 1'b1);
                end
            end
            CMD_REM_HEAD, CMD_REM_TAIL: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    n_count = CW'(r_count - 1'b1);
                    if (i_item.command == CMD_REM_HEAD) begin
                        n_head = (r_head == PW'(CAPACITY - 1)) ? '0 : PW'(r_head + 1'b1);
                    end
                end
            end
            CMD_RD_HEAD, CMD_RD_TAIL: begin
                offset = (i_item.command == CMD_RD_HEAD) ? '0 : PW'(r_count - 1'b1);
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    mem_re = 1'b1;
                    rd_ok = 1'b1;
                end
            end
            CMD_RD_INDEX: begin
                offset = PW'(i_item.position);
                if (empty) begin
                    status = ST_EMPTY;
                end else if (16'(i_item.position) >= 16'(r_count)) begin
                    status = ST_RANGE;
                end else begin
                    mem_re = 1'b1;
                    rd_ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && mem_we) begin
            r_mem[addr] <= ELEMENT_WIDTH'(i_item.element_in);
        end
        if (accept && mem_re) begin
            r_rdata <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_count <= '0;
            r_s1_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head <= n_head;
                r_count <= n_count;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rd <= rd_ok;
            r_s1_count <= COUNT_IO_W'(n_count);
            r_s1_status <= status;
        end
        if (s1_adv) begin
            r_out.element_out <= r_s1_rd ? ELEM_IO_W'(r_rdata) : '0;
            r_out.entry_count <= r_s1_count;
            r_out.status <= r_s1_status;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
